// ----- rtl/core/mbce_pkg.sv -----
// mbce_pkg: shared types and constants for the monochrome color expander
// no dependencies; compiled first
`default_nettype none

package mbce_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_DEPTH_MODE     = 3'd0;
   localparam logic [2:0] REG_FG_COLOR       = 3'd1;
   localparam logic [2:0] REG_BG_COLOR       = 3'd2;
   localparam logic [2:0] REG_FG_COLOR16     = 3'd3;
   localparam logic [2:0] REG_BG_COLOR16     = 3'd4;
   localparam logic [2:0] REG_LINE_WIDTH     = 3'd5;
   localparam logic [2:0] REG_START_BIT      = 3'd6;
   localparam logic [2:0] REG_SRC_LINE_BYTES = 3'd7;

   // destination depth codes, anything above 32 bpp acts as 32 bpp
   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_8BPP  = 3'd1;
   localparam logic [2:0] DEPTH_16BPP = 3'd2;
   localparam logic [2:0] DEPTH_24BPP = 3'd3;
   localparam logic [2:0] DEPTH_32BPP = 3'd4;

   localparam logic [12:0] MAX_LINE_PIXELS = 13'd4096;
   localparam logic [10:0] MAX_LINE_BYTES  = 11'd1024;
   localparam logic [10:0] BYTE_IDX_MAX    = 11'd2047;
   localparam logic [7:0]  MSB_MASK        = 8'h80;

   typedef struct packed {
      logic [2:0]  depth_mode;
      logic [31:0] fg_color;
      logic [31:0] bg_color;
      logic [15:0] fg_color16;
      logic [15:0] bg_color16;
      logic [12:0] line_width;
      logic [2:0]  start_bit;
      logic [10:0] src_line_bytes;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/core/mbce_req_if.sv -----
// mbce_req_if: valid/ready channel carrying one source byte
// no dependencies
`default_nettype none

interface mbce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;

   modport source (output valid, output src_byte, input ready);
   modport sink (input valid, input src_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mbce_rsp_if.sv -----
// mbce_rsp_if: valid/ready channel carrying one destination byte and flags
// no dependencies
`default_nettype none

interface mbce_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_item;
   logic       line_end;

   modport source (output valid, output out_byte, output last_of_item,
                   output line_end, input ready);
   modport sink (input valid, input out_byte, input last_of_item,
                 input line_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mbce_expand.sv -----
// mbce_expand: pixel sequencer and output register of the color expander
// depends on mbce_pkg, mbce_req_if, mbce_rsp_if
`default_nettype none

module mbce_expand (
   input  logic             clock,
   input  logic             reset,
   input  mbce_pkg::cfg_type cfg,
   mbce_req_if.sink         req_ch,
   mbce_rsp_if.source       rsp_ch
);
   import mbce_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  src_ff, src_in;
   logic [2:0]  k_ff, k_in;
   logic [1:0]  byte_sel_ff, byte_sel_in;
   logic [12:0] pixel_index_ff, pixel_index_in;
   logic [10:0] src_byte_index_ff, src_byte_index_in;
   logic [7:0]  pack_accum_ff, pack_accum_in;
   logic [2:0]  pack_count_ff, pack_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_line_end_ff, rsp_line_end_in;

   logic [12:0] width_eff;
   logic [10:0] slb_eff;
   logic        pix_done;
   logic [12:0] pix_next;
   logic        px_last;
   logic        px_set;
   logic [12:0] remain;
   logic [2:0]  k_left;
   logic        later_flush;
   logic        is_pack;
   logic [1:0]  nbytes_m1;
   logic        px_emits;
   logic        byte_final;
   logic [31:0] color32;
   logic [15:0] color16;
   logic [7:0]  px_byte;
   logic        item_final;
   logic        out_free;
   logic        run_active;
   logic        emit;
   logic        advance;
   logic        req_xfer;
   logic [10:0] sbi_next;

   assign width_eff = (cfg.line_width > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : cfg.line_width;

   always_comb begin
      if (cfg.src_line_bytes > MAX_LINE_BYTES) begin
         slb_eff = MAX_LINE_BYTES;
      end else if (cfg.src_line_bytes == 11'd0) begin
         slb_eff = 11'd1;
      end else begin
         slb_eff = cfg.src_line_bytes;
      end
   end

   // one pixel evaluated per step: compare, increment and byte select
   assign pix_done    = pixel_index_ff >= width_eff;
   assign pix_next    = pixel_index_ff + 13'd1;
   assign px_last     = pix_next == width_eff;
   assign px_set      = src_ff[3'd7 - k_ff];
   assign remain      = width_eff - pix_next;
   assign k_left      = 3'd7 - k_ff;
   // in 1 bpp a flush later in this byte only happens at line end
   assign later_flush = remain > {10'd0, k_left};
   assign is_pack     = cfg.depth_mode == DEPTH_1BPP;
   assign color32     = px_set ? cfg.fg_color : cfg.bg_color;
   assign color16     = px_set ? cfg.fg_color16 : cfg.bg_color16;

   always_comb begin
      case (cfg.depth_mode)
         DEPTH_1BPP: begin
            nbytes_m1 = 2'd0;
            px_byte   = pack_accum_ff | (px_set ? (MSB_MASK >> pack_count_ff) : 8'h00);
         end
         DEPTH_8BPP: begin
            nbytes_m1 = 2'd0;
            px_byte   = {7'd0, px_set};
         end
         DEPTH_16BPP: begin
            nbytes_m1 = 2'd1;
            px_byte   = byte_sel_ff[0] ? color16[15:8] : color16[7:0];
         end
         default: begin
            nbytes_m1 = (cfg.depth_mode == DEPTH_24BPP) ? 2'd2 : 2'd3;
            case (byte_sel_ff)
               2'd0:    px_byte = color32[7:0];
               2'd1:    px_byte = color32[15:8];
               2'd2:    px_byte = color32[23:16];
               default: px_byte = color32[31:24];
            endcase
         end
      endcase
   end

   assign px_emits   = !is_pack || (pack_count_ff == 3'd7) || px_last;
   assign byte_final = byte_sel_ff == nbytes_m1;
   assign item_final = byte_final &&
                       ((k_ff == 3'd7) || px_last || (is_pack && later_flush));

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign run_active = (state_ff == ST_RUN) && !pix_done;
   assign emit       = run_active && px_emits && out_free;
   assign advance    = run_active && (px_emits ? (out_free && byte_final) : 1'b1);
   assign req_xfer   = req_ch.valid && req_ch.ready;
   assign sbi_next   = (src_byte_index_ff < BYTE_IDX_MAX) ? src_byte_index_ff + 11'd1
                                                          : src_byte_index_ff;

   always_comb begin
      state_in          = state_ff;
      src_in            = src_ff;
      k_in              = k_ff;
      byte_sel_in       = byte_sel_ff;
      pixel_index_in    = pixel_index_ff;
      src_byte_index_in = src_byte_index_ff;
      pack_accum_in     = pack_accum_ff;
      pack_count_in     = pack_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               src_in      = req_ch.src_byte;
               k_in        = (src_byte_index_ff == 11'd0) ? cfg.start_bit : 3'd0;
               byte_sel_in = 2'd0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pix_done) begin
               state_in = ST_DONE;
            end else if (advance) begin
               byte_sel_in    = 2'd0;
               pixel_index_in = pix_next;
               if (is_pack) begin
                  if (px_emits) begin
                     pack_accum_in = 8'h00;
                     pack_count_in = 3'd0;
                  end else begin
                     pack_accum_in = px_byte;
                     pack_count_in = pack_count_ff + 3'd1;
                  end
               end
               if (k_ff == 3'd7) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end else if (emit) begin
               byte_sel_in = byte_sel_ff + 2'd1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            // line ends once all pixels are out and enough bytes are consumed
            if (pix_done && (sbi_next >= slb_eff)) begin
               pixel_index_in    = 13'd0;
               src_byte_index_in = 11'd0;
               pack_accum_in     = 8'h00;
               pack_count_in     = 3'd0;
            end else begin
               src_byte_index_in = sbi_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_line_end_in = rsp_line_end_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_byte_in     = px_byte;
         rsp_last_in     = item_final;
         rsp_line_end_in = byte_final && px_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         k_ff              <= 3'd0;
         byte_sel_ff       <= 2'd0;
         pixel_index_ff    <= 13'd0;
         src_byte_index_ff <= 11'd0;
         pack_accum_ff     <= 8'h00;
         pack_count_ff     <= 3'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         k_ff              <= k_in;
         byte_sel_ff       <= byte_sel_in;
         pixel_index_ff    <= pixel_index_in;
         src_byte_index_ff <= src_byte_index_in;
         pack_accum_ff     <= pack_accum_in;
         pack_count_ff     <= pack_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff          <= src_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_line_end_ff <= rsp_line_end_in;
   end

   assign req_ch.ready        = state_ff == ST_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_byte_ff;
   assign rsp_ch.last_of_item = rsp_last_ff;
   assign rsp_ch.line_end     = rsp_line_end_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mono_bitmap_color_expand.sv -----
// mono_bitmap_color_expand: top level, csr registers and the pixel sequencer
// depends on mbce_pkg, mbce_req_if, mbce_rsp_if, mbce_expand
//
//   channel  dir  transfer when        payload
//   req_ch   in   valid & ready        src_byte
//   rsp_ch   out  valid & ready        out_byte, last_of_item, line_end
//   csr_*    in   csr_wen              csr_index, csr_wdata
//
// a source byte is accepted in ST_IDLE, then ST_RUN steps through its pixels
// and ST_DONE closes it, with one more step when the line ends inside the
// byte; each output byte is one step of the sequencer, and 1 bpp pixels
// that do not complete a byte take a step each
// reset is synchronous; it returns the registers to their defaults and the
// line position to the start of a line
// a stalled rsp_ch holds the sequencer on the byte it wants to send
`default_nettype none

module mono_bitmap_color_expand (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   mbce_req_if.sink    req_ch,
   mbce_rsp_if.source  rsp_ch
);
   import mbce_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            REG_DEPTH_MODE:     cfg_in.depth_mode     = csr_wdata[2:0];
            REG_FG_COLOR:       cfg_in.fg_color       = csr_wdata;
            REG_BG_COLOR:       cfg_in.bg_color       = csr_wdata;
            REG_FG_COLOR16:     cfg_in.fg_color16     = csr_wdata[15:0];
            REG_BG_COLOR16:     cfg_in.bg_color16     = csr_wdata[15:0];
            REG_LINE_WIDTH:     cfg_in.line_width     = csr_wdata[12:0];
            REG_START_BIT:      cfg_in.start_bit      = csr_wdata[2:0];
            REG_SRC_LINE_BYTES: cfg_in.src_line_bytes = csr_wdata[10:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode     <= DEPTH_32BPP;
         cfg_ff.fg_color       <= 32'hFFFF_FFFF;
         cfg_ff.bg_color       <= 32'h0000_0000;
         cfg_ff.fg_color16     <= 16'hFFFF;
         cfg_ff.bg_color16     <= 16'h0000;
         cfg_ff.line_width     <= 13'd1;
         cfg_ff.start_bit      <= 3'd0;
         cfg_ff.src_line_bytes <= 11'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbce_expand u_expand (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- dv/mono_bitmap_color_expand_check.sv -----
// mono_bitmap_color_expand_check: watches the csr port and both channels, predicts
// every destination byte from the accepted source bytes and compares in order
// depends on mbce_pkg

module mono_bitmap_color_expand_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_src_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_of_item,
   input  logic        rsp_line_end,
   output int          mismatches,
   output int          bytes_owed,
   output int          bytes_in,
   output int          bytes_out
);
   timeunit 1ns;
   timeprecision 1ps;
   import mbce_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       line_end;
   } dst_byte_type;

   cfg_type      cfg;
   logic [12:0]  pix_pos;
   logic [10:0]  src_pos;
   logic [7:0]   pack_bits;
   int           pack_fill;
   dst_byte_type owed_bytes[$];

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns: %s: got %h, expected %h (destination byte %0d)",
               $time, what, got, want, bytes_out);
      mismatches++;
   endtask

   task automatic owe_byte(input logic [7:0] value, input logic line_last);
      dst_byte_type entry;
      entry.out_byte = value;
      entry.last_of_item = 1'b0;
      entry.line_end = line_last;
      owed_bytes.push_back(entry);
   endtask

   task automatic clear_line();
      pix_pos = '0;
      src_pos = '0;
      pack_bits = '0;
      pack_fill = 0;
   endtask

   // expand one source byte into the destination bytes it produces
   task automatic expand_src_byte(input logic [7:0] src);
      int           width;
      int           src_len;
      int           k;
      int           i;
      int           nb;
      int           owed_before;
      logic         set;
      logic         last;
      logic [31:0]  color;
      dst_byte_type tail;
      owed_before = owed_bytes.size();
      width = (cfg.line_width > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : cfg.line_width;
      src_len = (cfg.src_line_bytes > MAX_LINE_BYTES) ? MAX_LINE_BYTES
                                                      : cfg.src_line_bytes;
      if (src_len == 0) src_len = 1;
      k = (src_pos == 0) ? cfg.start_bit : 0;
      while (k < 8 && pix_pos < width) begin
         set = src[7 - k];
         last = (pix_pos + 1 == width);
         pix_pos = pix_pos + 13'd1;
         case (cfg.depth_mode)
            DEPTH_1BPP: begin
               if (set) pack_bits[7 - pack_fill] = 1'b1;
               pack_fill++;
               if (pack_fill >= 8 || last) begin
                  owe_byte(pack_bits, last);
                  pack_bits = '0;
                  pack_fill = 0;
               end
            end
            DEPTH_8BPP: owe_byte({7'd0, set}, last);
            DEPTH_16BPP: begin
               color = set ? cfg.fg_color16 : cfg.bg_color16;
               owe_byte(color[7:0], 1'b0);
               owe_byte(color[15:8], last);
            end
            default: begin
               // 24 bpp and 32 bpp, codes above 32 bpp included
               color = set ? cfg.fg_color : cfg.bg_color;
               nb = (cfg.depth_mode == DEPTH_24BPP) ? 3 : 4;
               for (i = 0; i < nb; i++)
                  owe_byte(color[8*i +: 8], (i == nb - 1) ? last : 1'b0);
            end
         endcase
         k++;
      end
      if (src_pos < BYTE_IDX_MAX) src_pos = src_pos + 11'd1;
      if (pix_pos >= width && src_pos >= src_len) clear_line();
      if (owed_bytes.size() > owed_before) begin
         tail = owed_bytes.pop_back();
         tail.last_of_item = 1'b1;
         owed_bytes.push_back(tail);
      end
   endtask

   task automatic compare_dst_byte();
      dst_byte_type want;
      if (owed_bytes.size() == 0) begin
         report_mismatch("destination byte with nothing owed", rsp_out_byte, 8'h00);
      end else begin
         want = owed_bytes.pop_front();
         if (rsp_out_byte !== want.out_byte)
            report_mismatch("out_byte", rsp_out_byte, want.out_byte);
         if (rsp_last_of_item !== want.last_of_item)
            report_mismatch("last_of_item", {7'd0, rsp_last_of_item},
                            {7'd0, want.last_of_item});
         if (rsp_line_end !== want.line_end)
            report_mismatch("line_end", {7'd0, rsp_line_end}, {7'd0, want.line_end});
      end
      bytes_out++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.depth_mode = DEPTH_32BPP;
         cfg.fg_color = 32'hFFFF_FFFF;
         cfg.bg_color = 32'h0;
         cfg.fg_color16 = 16'hFFFF;
         cfg.bg_color16 = 16'h0;
         cfg.line_width = 13'd1;
         cfg.start_bit = 3'd0;
         cfg.src_line_bytes = 11'd1;
         clear_line();
         owed_bytes.delete();
         mismatches = 0;
         bytes_in = 0;
         bytes_out = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_DEPTH_MODE:     cfg.depth_mode = csr_wdata[2:0];
               REG_FG_COLOR:       cfg.fg_color = csr_wdata;
               REG_BG_COLOR:       cfg.bg_color = csr_wdata;
               REG_FG_COLOR16:     cfg.fg_color16 = csr_wdata[15:0];
               REG_BG_COLOR16:     cfg.bg_color16 = csr_wdata[15:0];
               REG_LINE_WIDTH:     cfg.line_width = csr_wdata[12:0];
               REG_START_BIT:      cfg.start_bit = csr_wdata[2:0];
               REG_SRC_LINE_BYTES: cfg.src_line_bytes = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expand_src_byte(req_src_byte);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) compare_dst_byte();
      end
      bytes_owed = owed_bytes.size();
   end

endmodule

// ----- dv/mono_bitmap_color_expand_tb.sv -----
// mono_bitmap_color_expand_tb: clock, reset, register setups and source byte stimulus
// with random stalls on both channels; verdict comes from the checker's count
// depends on mbce_pkg, mbce_req_if, mbce_rsp_if, mono_bitmap_color_expand(_check)

module mono_bitmap_color_expand_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbce_pkg::*;

   localparam logic [2:0] DEPTH_UNDEF_HI = 3'd7;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        idle_on;
   int          mismatches;
   int          bytes_owed;
   int          bytes_in;
   int          bytes_out;
   int          setups = 0;
   int          cycles = 0;

   mbce_req_if req_ch ();
   mbce_rsp_if rsp_ch ();

   mono_bitmap_color_expand dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   mono_bitmap_color_expand_check pixel_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_src_byte     (req_ch.src_byte),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_byte     (rsp_ch.out_byte),
      .rsp_last_of_item (rsp_ch.last_of_item),
      .rsp_line_end     (rsp_ch.line_end),
      .mismatches       (mismatches),
      .bytes_owed       (bytes_owed),
      .bytes_in         (bytes_in),
      .bytes_out        (bytes_out)
   );

   always #5 clock = ~clock;

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timed out after %0d cycles, %0d destination bytes still owed",
               cycles, bytes_owed);
      $display("mono_bitmap_color_expand_tb: FAIL");
      $finish;
   end

   // destination side stalls in bursts while idle_on is set
   initial begin : rsp_backpressure
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_color();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // called right after a rising edge; returns right after the edge of the transfer
   task automatic send_byte(input logic [7:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.src_byte <= value;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random(input int count);
      int n;
      for (n = 0; n < count; n++) send_byte(8'($urandom_range(0, 255)));
   endtask

   // wait for every owed byte, then for bytes that produce nothing to finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (bytes_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [2:0] depth, input logic [31:0] fg,
                               input logic [31:0] bg, input logic [15:0] fg16,
                               input logic [15:0] bg16, input logic [12:0] width,
                               input logic [2:0] sbit, input logic [10:0] slb);
      logic [31:0] vals [0:7];
      int          r;
      vals[REG_DEPTH_MODE] = 32'(depth);
      vals[REG_FG_COLOR] = fg;
      vals[REG_BG_COLOR] = bg;
      vals[REG_FG_COLOR16] = 32'(fg16);
      vals[REG_BG_COLOR16] = 32'(bg16);
      vals[REG_LINE_WIDTH] = 32'(width);
      vals[REG_START_BIT] = 32'(sbit);
      vals[REG_SRC_LINE_BYTES] = 32'(slb);
      for (r = 0; r < 8; r++) begin
         csr_wen <= 1'b1;
         csr_index <= 3'(r);
         csr_wdata <= vals[r];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      setups++;
   endtask

   initial begin : stimulus
      int          ph;
      int          n_bytes;
      int          needed;
      logic [2:0]  depth;
      logic [2:0]  sbit;
      logic [12:0] width;
      logic [10:0] slb;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = REG_DEPTH_MODE;
      csr_wdata = 32'h0;
      req_ch.valid = 1'b0;
      req_ch.src_byte = 8'h00;
      idle_on = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: 32 bpp, one pixel per one-byte line
      send_byte(8'h80);
      send_byte(8'h7F);
      settle();

      // 1 bpp with a start offset, a padded partial byte and a padding source byte
      program_regs(DEPTH_1BPP, 32'h0, 32'h0, 16'h0, 16'h0, 13'd11, 3'd7 - 3'd4, 11'd3);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h3C);
      send_byte(8'hC3);
      send_byte(8'h5A);
      settle();

      // 8 bpp index, last bit as the first pixel, zero source bytes per line
      program_regs(DEPTH_8BPP, 32'h0, 32'h0, 16'h0, 16'h0, 13'd3, 3'd7, 11'd0);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'hFE);
      settle();

      // 16 bpp with a source line shorter than its pixels need
      program_regs(DEPTH_16BPP, 32'h0, 32'hFFFF_FFFF, 16'h8001, 16'h7FFE, 13'd9, 3'd0,
                   11'd1);
      send_byte(8'hAA);
      send_byte(8'h55);
      settle();

      // zero line width: bytes consumed, nothing produced
      program_regs(DEPTH_24BPP, 32'h1234_5678, 32'hFFFF_FFFF, 16'h0, 16'h0, 13'd0,
                   3'd0, 11'd2);
      send_byte(8'hFF);
      send_byte(8'h00);
      settle();

      // undefined depth code behaves as 32 bpp
      program_regs(DEPTH_UNDEF_HI, 32'hDEAD_BEEF, 32'h0, 16'h0, 16'h0, 13'd2, 3'd6,
                   11'd1);
      send_byte(8'h02);
      settle();

      // width lowered below the pixels already expanded in the line
      program_regs(DEPTH_8BPP, 32'h0, 32'h0, 16'h0, 16'h0, 13'd20, 3'd0, 11'd1);
      send_byte(8'hC3);
      settle();
      program_regs(DEPTH_8BPP, 32'h0, 32'h0, 16'h0, 16'h0, 13'd4, 3'd0, 11'd1);
      send_byte(8'hFF);
      send_byte(8'h81);
      settle();

      // both line registers above their maximum, first part of such a line
      program_regs(DEPTH_1BPP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 13'h1FFF, 3'd0,
                   11'h7FF);
      send_random(40);
      settle();

      for (ph = 0; ph < 14; ph++) begin
         if (ph == 11) idle_on <= 1'b0;
         depth = 3'($urandom_range(0, 7));
         sbit = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: width = 13'd0;
            1: width = 13'($urandom_range(100, 300));
            default: width = 13'($urandom_range(1, 40));
         endcase
         needed = (sbit + width + 7) / 8;
         if (needed < 1) needed = 1;
         case ($urandom_range(0, 5))
            0: slb = 11'd0;
            1: slb = 11'($urandom_range(1, needed));
            default: slb = 11'(needed + $urandom_range(0, 3));
         endcase
         program_regs(depth, pick_color(), pick_color(), 16'(pick_color()),
                      16'(pick_color()), width, sbit, slb);
         n_bytes = $urandom_range(12, 24);
         send_random(n_bytes);
         settle();
      end

      @(negedge clock);
      $display("%0d source bytes in, %0d destination bytes checked, %0d register setups",
               bytes_in, bytes_out, setups);
      $display("directed depth and line cases, then random depth codes, widths and lengths");
      if (mismatches == 0 && bytes_owed == 0) begin
         $display("mono_bitmap_color_expand_tb: PASS");
      end else begin
         $display("mono_bitmap_color_expand_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mbce_pkg.sv
rtl/core/mbce_req_if.sv
rtl/core/mbce_rsp_if.sv
rtl/core/mbce_expand.sv
rtl/core/mono_bitmap_color_expand.sv
dv/mono_bitmap_color_expand_check.sv
dv/mono_bitmap_color_expand_tb.sv
